### src/lav_pkg.sv
// Shared constants, types and rounding helper for the look-at view matrix pipeline.
package lav_pkg;

	// Fixed-point format and word sizes
	localparam int FRAC_BITS = 16;
	localparam int WORD_W    = 32;
	localparam int IN_DW     = 9 * WORD_W;
	localparam int OUT_DW    = 12 * WORD_W;

	// Unit axis components never exceed 1.0 in magnitude
	localparam int AXW       = FRAC_BITS + 2;
	// Normalizer input: covers a 33-bit difference and a view x hint cross product
	localparam int NORM_IN_W = FRAC_BITS + 34;
	localparam int NORM_S    = $clog2(NORM_IN_W);

	// Scaled magnitudes sit in [2^29, 2^30)
	localparam int M_W      = 30;
	localparam int SUM_W    = 2 * M_W + 2;
	localparam int SQ_STEPS = 31;
	localparam int LEN_W    = 31;
	localparam int QW       = FRAC_BITS + 1;
	localparam int DW       = M_W + FRAC_BITS + 1;

	// Normalizer latency: magnitude, shifter, square, square root, divider, sign
	localparam int NORM_LAT = NORM_S + QW + 36;

	// Wide accumulator width for rounding and saturation
	localparam int RS_W = 2 * WORD_W + 3;

	typedef logic signed [WORD_W-1:0]    word_t;
	typedef logic signed [AXW-1:0]       ax_t;
	typedef logic signed [NORM_IN_W-1:0] nin_t;
	typedef word_t [2:0] word_vec_t;
	typedef ax_t   [2:0] ax_vec_t;
	typedef nin_t  [2:0] nin_vec_t;

	localparam logic [RS_W-1:0]   RND_HALF = RS_W'(1) << (FRAC_BITS - 1);
	localparam logic signed [RS_W:0] SAT_HI = (RS_W+1)'(2147483647);
	localparam logic signed [RS_W:0] SAT_LO = -((RS_W+1)'(2147483647)) - (RS_W+1)'(1);

	// Drop the fraction bits, round half away from zero, clamp to a signed word.
	// flip negates the value first.
	function automatic word_t rnd_sat(input logic signed [RS_W-1:0] v, input logic flip);
		logic              neg;
		logic [RS_W-1:0]   mag;
		logic [RS_W-1:0]   rm;
		logic signed [RS_W:0] r;
		neg = flip ? (v > 0) : (v < 0);
		mag = (v < 0) ? RS_W'(-v) : RS_W'(v);
		rm  = (mag + RND_HALF) >> FRAC_BITS;
		r   = neg ? -$signed({1'b0, rm}) : $signed({1'b0, rm});
		if (r > SAT_HI) begin
			r = SAT_HI;
		end else if (r < SAT_LO) begin
			r = SAT_LO;
		end
		return word_t'(r[WORD_W-1:0]);
	endfunction

endpackage

### src/lav_norm.sv
// Pipelined 3-vector normalizer: scale, square root, per-component divide.
module lav_norm
	import lav_pkg::*;
(
	input  logic     clk,
	input  logic     en,
	input  nin_vec_t vec,
	output ax_vec_t  unit
);

	typedef logic [NORM_IN_W-1:0] mag_t;
	typedef mag_t [2:0] mag_vec_t;
	typedef logic [M_W-1:0] m_t;
	typedef m_t [2:0] m_vec_t;
	typedef logic [DW-1:0] rem_t;
	typedef rem_t [2:0] rem_vec_t;
	typedef logic [QW-1:0] q_t;
	typedef q_t [2:0] q_vec_t;

	localparam mag_t ALL_ONES = '1;

	mag_vec_t          shv_s [0:NORM_S];
	logic [2:0]        neg_s [0:NORM_LAT-2];
	m_vec_t            sqm_s;
	logic [2*M_W-1:0]  sq_s  [0:2];
	logic [SUM_W-1:0]  rn_s  [0:SQ_STEPS];
	logic [SUM_W-1:0]  rr_s  [0:SQ_STEPS];
	m_vec_t            rm_s  [0:SQ_STEPS];
	rem_vec_t          rem_s [0:QW];
	q_vec_t            q_s   [0:QW];
	logic [LEN_W-1:0]  len_s [0:QW];

	logic [NORM_S-1:0] sh_go;
	logic [SUM_W-1:0]  sq_bit [0:SQ_STEPS-1];
	logic [SUM_W-1:0]  sq_try [0:SQ_STEPS-1];
	logic              sq_go  [0:SQ_STEPS-1];
	logic [LEN_W-1:0]  sq_len;
	rem_vec_t          dv_sub [0:QW-1];
	logic [2:0]        dv_go  [0:QW-1];

	// Shift decisions: move left when the top bits of all magnitudes are clear
	always_comb begin
		for (int j = 0; j < NORM_S; j++) begin
			sh_go[j] = (((shv_s[j][0] | shv_s[j][1] | shv_s[j][2]) &
				~(ALL_ONES >> (1 << (NORM_S - 1 - j)))) == '0);
		end
	end

	// Square root digit trials
	always_comb begin
		for (int k = 0; k < SQ_STEPS; k++) begin
			sq_bit[k] = SUM_W'(1) << (2 * (SQ_STEPS - 1 - k));
			sq_try[k] = rr_s[k] + sq_bit[k];
			sq_go[k]  = (rn_s[k] >= sq_try[k]);
		end
		sq_len = rr_s[SQ_STEPS][LEN_W-1:0];
	end

	// Divider trial subtrahends
	always_comb begin
		for (int t = 0; t < QW; t++) begin
			for (int i = 0; i < 3; i++) begin
				dv_sub[t][i] = DW'(len_s[t]) << (QW - 1 - t);
				dv_go[t][i]  = (rem_s[t][i] >= dv_sub[t][i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// Magnitudes and signs
			for (int i = 0; i < 3; i++) begin
				shv_s[0][i] <= vec[i][NORM_IN_W-1] ? mag_t'(-vec[i]) : mag_t'(vec[i]);
			end
			neg_s[0] <= {vec[2][NORM_IN_W-1], vec[1][NORM_IN_W-1], vec[0][NORM_IN_W-1]};
			for (int k = 1; k <= NORM_LAT - 2; k++) begin
				neg_s[k] <= neg_s[k-1];
			end

			// Log shifter: leading one of the largest magnitude to the top
			for (int j = 0; j < NORM_S; j++) begin
				for (int i = 0; i < 3; i++) begin
					shv_s[j+1][i] <= sh_go[j] ? (shv_s[j][i] << (1 << (NORM_S - 1 - j)))
						: shv_s[j][i];
				end
			end

			// Keep the top bits and square them
			for (int i = 0; i < 3; i++) begin
				sqm_s[i] <= shv_s[NORM_S][i][NORM_IN_W-1 -: M_W];
				sq_s[i]  <= (2*M_W)'(shv_s[NORM_S][i][NORM_IN_W-1 -: M_W]) *
					(2*M_W)'(shv_s[NORM_S][i][NORM_IN_W-1 -: M_W]);
			end

			// Sum of squares, square root one result bit per stage
			rn_s[0] <= SUM_W'(sq_s[0]) + SUM_W'(sq_s[1]) + SUM_W'(sq_s[2]);
			rr_s[0] <= '0;
			rm_s[0] <= sqm_s;
			for (int k = 0; k < SQ_STEPS; k++) begin
				rn_s[k+1] <= sq_go[k] ? (rn_s[k] - sq_try[k]) : rn_s[k];
				rr_s[k+1] <= sq_go[k] ? ((rr_s[k] >> 1) + sq_bit[k]) : (rr_s[k] >> 1);
				rm_s[k+1] <= rm_s[k];
			end

			// Rounded dividend, then restoring division one quotient bit per stage
			for (int i = 0; i < 3; i++) begin
				rem_s[0][i] <= (DW'(rm_s[SQ_STEPS][i]) << FRAC_BITS) + DW'(sq_len >> 1);
			end
			q_s[0]   <= '0;
			len_s[0] <= sq_len;
			for (int t = 0; t < QW; t++) begin
				for (int i = 0; i < 3; i++) begin
					rem_s[t+1][i] <= dv_go[t][i] ? (rem_s[t][i] - dv_sub[t][i]) : rem_s[t][i];
					q_s[t+1][i]   <= {q_s[t][i][QW-2:0], dv_go[t][i]};
				end
				len_s[t+1] <= len_s[t];
			end

			// Restore sign; a zero vector has zero length and gives zero
			for (int i = 0; i < 3; i++) begin
				if (len_s[QW] == '0) begin
					unit[i] <= '0;
				end else if (neg_s[NORM_LAT-2][i]) begin
					unit[i] <= -$signed({1'b0, q_s[QW][i]});
				end else begin
					unit[i] <= $signed({1'b0, q_s[QW][i]});
				end
			end
		end
	end

endmodule

### src/look_at_view_matrix.sv
// Top level of the look-at view matrix pipeline.
//
// Input channel s_axis: one item per camera view, nine signed Q16.16 words
// (position, target, up hint). Output channel m_axis: twelve signed Q16.16
// words (right, view and up axes, then the three translation terms).
// Throughput is one item per cycle unless the receiver stalls. The depth of
// the pipeline is set by the two normalizers, each with a 31-stage square root
// and a FRAC_BITS+1 stage divider, plus the cross product and dot stages.
// Every item is independent; there is no configuration.
// Reset clears all valid bits; payload registers are not reset.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_axis_tready drops; nothing is lost or repeated. Bubbles move on
// whenever the output register is empty or being taken.
module look_at_view_matrix
	import lav_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	// from_x, from_y, from_z, target_x, target_y, target_z,
	// hint_up_x, hint_up_y, hint_up_z (32 bits each)
	input  logic [IN_DW-1:0]  s_axis_tdata,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	// right_x, right_y, right_z, view_x, view_y, view_z, true_up_x, true_up_y,
	// true_up_z, shift_right, shift_view, shift_up (32 bits each)
	output logic [OUT_DW-1:0] m_axis_tdata
);

	localparam int L    = NORM_LAT;
	localparam int LAT  = 2 * L + 9;
	localparam int PW   = AXW + WORD_W;
	localparam int CW   = 2 * AXW;
	localparam ax_t AX_ONE  = ax_t'(2 ** FRAC_BITS);
	localparam ax_t AX_MONE = ax_t'(-(2 ** FRAC_BITS));

	logic      en;
	logic      vld_s [0:LAT-1];

	word_vec_t in_from, in_target, in_hint;
	word_vec_t frm_s  [0:2*L+5];
	word_vec_t hint_s [0:L];
	nin_vec_t  diff_s1;
	ax_vec_t   view_n, right_n;
	ax_vec_t   vw_s [0:L+7];
	ax_vec_t   rt_s [0:5];

	logic signed [PW-1:0]    c1p_s [0:5];
	nin_vec_t                raw_s;
	logic signed [CW-1:0]    c2p_s [0:5];
	logic signed [PW-1:0]    dr_s  [0:2];
	logic signed [PW-1:0]    dv_s  [0:2];
	logic signed [CW:0]      upr_s [0:2];
	logic signed [PW+1:0]    sdr_s, sdv_s;
	word_vec_t               up_s;
	word_t                   shr_s, shv_s;
	logic signed [2*WORD_W-1:0] upp_s [0:2];
	logic signed [2*WORD_W+1:0] sdu_s;
	word_t                   shu_s;
	word_vec_t               up_d  [0:2];
	word_t                   shr_d [0:2];
	word_t                   shv_d [0:2];

	// Whole pipeline advances unless a result waits on a stalled receiver
	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = vld_s[LAT-1];

	// Unpack the input item
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			in_from[i]   = word_t'(s_axis_tdata[i*WORD_W +: WORD_W]);
			in_target[i] = word_t'(s_axis_tdata[(3+i)*WORD_W +: WORD_W]);
			in_hint[i]   = word_t'(s_axis_tdata[(6+i)*WORD_W +: WORD_W]);
		end
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LAT; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (en) begin
			vld_s[0] <= s_axis_tvalid;
			for (int k = 1; k < LAT; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	// View direction and right axis normalizers
	lav_norm u_norm_view (
		.clk  (clk),
		.en   (en),
		.vec  (diff_s1),
		.unit (view_n)
	);

	lav_norm u_norm_right (
		.clk  (clk),
		.en   (en),
		.vec  (raw_s),
		.unit (right_n)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			// Input stage: difference kept wide so it never wraps
			for (int i = 0; i < 3; i++) begin
				diff_s1[i] <= nin_t'(in_target[i]) - nin_t'(in_from[i]);
			end
			frm_s[0]  <= in_from;
			hint_s[0] <= in_hint;
			for (int k = 1; k <= 2 * L + 5; k++) begin
				frm_s[k] <= frm_s[k-1];
			end
			for (int k = 1; k <= L; k++) begin
				hint_s[k] <= hint_s[k-1];
			end

			// Carry the view axis to the output
			vw_s[0] <= view_n;
			for (int k = 1; k <= L + 7; k++) begin
				vw_s[k] <= vw_s[k-1];
			end

			// Cross product view x hint: products, then differences
			c1p_s[0] <= PW'(view_n[1]) * PW'(hint_s[L][2]);
			c1p_s[1] <= PW'(view_n[2]) * PW'(hint_s[L][1]);
			c1p_s[2] <= PW'(view_n[2]) * PW'(hint_s[L][0]);
			c1p_s[3] <= PW'(view_n[0]) * PW'(hint_s[L][2]);
			c1p_s[4] <= PW'(view_n[0]) * PW'(hint_s[L][1]);
			c1p_s[5] <= PW'(view_n[1]) * PW'(hint_s[L][0]);
			for (int i = 0; i < 3; i++) begin
				raw_s[i] <= nin_t'((PW+1)'(c1p_s[2*i]) - (PW+1)'(c1p_s[2*i+1]));
			end

			// Right axis carried to the output
			rt_s[0] <= right_n;
			for (int k = 1; k <= 5; k++) begin
				rt_s[k] <= rt_s[k-1];
			end

			// Cross product right x view and dot products with the position
			c2p_s[0] <= CW'(right_n[1]) * CW'(vw_s[L+1][2]);
			c2p_s[1] <= CW'(right_n[2]) * CW'(vw_s[L+1][1]);
			c2p_s[2] <= CW'(right_n[2]) * CW'(vw_s[L+1][0]);
			c2p_s[3] <= CW'(right_n[0]) * CW'(vw_s[L+1][2]);
			c2p_s[4] <= CW'(right_n[0]) * CW'(vw_s[L+1][1]);
			c2p_s[5] <= CW'(right_n[1]) * CW'(vw_s[L+1][0]);
			for (int i = 0; i < 3; i++) begin
				dr_s[i] <= PW'(right_n[i]) * PW'(frm_s[2*L+2][i]);
				dv_s[i] <= PW'(vw_s[L+1][i]) * PW'(frm_s[2*L+2][i]);
			end

			// Sums
			for (int i = 0; i < 3; i++) begin
				upr_s[i] <= (CW+1)'(c2p_s[2*i]) - (CW+1)'(c2p_s[2*i+1]);
			end
			sdr_s <= (PW+2)'(dr_s[0]) + (PW+2)'(dr_s[1]) + (PW+2)'(dr_s[2]);
			sdv_s <= (PW+2)'(dv_s[0]) + (PW+2)'(dv_s[1]) + (PW+2)'(dv_s[2]);

			// Round and saturate
			for (int i = 0; i < 3; i++) begin
				up_s[i] <= rnd_sat(RS_W'(upr_s[i]), 1'b0);
			end
			shr_s <= rnd_sat(RS_W'(sdr_s), 1'b1);
			shv_s <= rnd_sat(RS_W'(sdv_s), 1'b1);

			// Dot of the up axis with the position
			for (int i = 0; i < 3; i++) begin
				upp_s[i] <= (2*WORD_W)'(up_s[i]) * (2*WORD_W)'(frm_s[2*L+5][i]);
			end
			sdu_s <= (2*WORD_W+2)'(upp_s[0]) + (2*WORD_W+2)'(upp_s[1]) +
				(2*WORD_W+2)'(upp_s[2]);
			shu_s <= rnd_sat(RS_W'(sdu_s), 1'b1);

			// Align the finished terms with the last stage
			up_d[0]  <= up_s;
			shr_d[0] <= shr_s;
			shv_d[0] <= shv_s;
			for (int k = 1; k <= 2; k++) begin
				up_d[k]  <= up_d[k-1];
				shr_d[k] <= shr_d[k-1];
				shv_d[k] <= shv_d[k-1];
			end
		end
	end

	// Pack the result item
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			m_axis_tdata[i*WORD_W +: WORD_W]     = WORD_W'(rt_s[5][i]);
			m_axis_tdata[(3+i)*WORD_W +: WORD_W] = WORD_W'(vw_s[L+7][i]);
			m_axis_tdata[(6+i)*WORD_W +: WORD_W] = up_d[2][i];
		end
		m_axis_tdata[9*WORD_W +: WORD_W]  = shr_d[2];
		m_axis_tdata[10*WORD_W +: WORD_W] = shv_d[2];
		m_axis_tdata[11*WORD_W +: WORD_W] = shu_s;
	end

	// An accepted item enters the first stage
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> vld_s[0])
		else $error("accepted item did not enter the pipeline");

	// Normalized view components stay within plus or minus one
	a_view_unit: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[L] |-> (view_n[0] <= AX_ONE && view_n[0] >= AX_MONE &&
			view_n[1] <= AX_ONE && view_n[1] >= AX_MONE &&
			view_n[2] <= AX_ONE && view_n[2] >= AX_MONE))
		else $error("view component out of unit range");

	// A zero view direction yields a zero right axis
	a_zero_right: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[2*L+2] && (vw_s[L+1] == '0) |-> (right_n == '0))
		else $error("zero view gave nonzero right axis");

endmodule

### verif/tb.sv
// Testbench for the look-at view matrix pipeline: random and directed camera views.
`timescale 1ns / 100ps

module tb
	import lav_pkg::*;
;

	localparam int LATENCY   = 127;
	localparam int WD_LIMIT  = 4000;
	localparam int N_RANDOM  = 1500;

	typedef struct packed {
		logic signed [31:0] hz, hy, hx, tz, ty, tx, fz, fy, fx;
	} view_in_t;

	logic              clk;
	logic              arst_n;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [IN_DW-1:0]  s_axis_tdata;
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic [OUT_DW-1:0] m_axis_tdata;

	view_in_t          pending_views[$];
	logic [OUT_DW-1:0] expected_mats[$];
	int                errors = 0;
	int                idle_cycles = 0;
	int                src_gap, snk_gap, hold_off;
	bit                quiet_phase;
	bit                src_pause;
	bit                all_queued;
	bit                hold_done;
	bit                in_taken;

	look_at_view_matrix dut (.*);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Magnitude of a 64-bit signed value
	function automatic logic [63:0] mag64(input logic signed [63:0] v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	function automatic logic [63:0] int_sqrt(input logic [63:0] n);
		logic [63:0] res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n = n - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// Scale so the largest magnitude is in [2^29, 2^30), then divide by the length
	function automatic void to_unit(input logic signed [63:0] v[3],
			output logic signed [63:0] o[3]);
		logic [63:0] m[3];
		logic [63:0] top, sum, len, q;
		for (int i = 0; i < 3; i++) m[i] = mag64(v[i]);
		top = m[0];
		if (m[1] > top) top = m[1];
		if (m[2] > top) top = m[2];
		if (top == 0) begin
			for (int i = 0; i < 3; i++) o[i] = 0;
			return;
		end
		while (top >= (64'd1 << 30)) begin
			top = top >> 1;
			for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
		end
		while (top < (64'd1 << 29)) begin
			top = top << 1;
			for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
		end
		sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
		len = int_sqrt(sum);
		for (int i = 0; i < 3; i++) begin
			q = ((m[i] << FRAC_BITS) + (len >> 1)) / len;
			o[i] = v[i] < 0 ? -$signed(q) : $signed(q);
		end
	endfunction

	function automatic void cross_vec(input logic signed [63:0] a[3],
			input logic signed [63:0] b[3], output logic signed [63:0] o[3]);
		o[0] = a[1] * b[2] - a[2] * b[1];
		o[1] = a[2] * b[0] - a[0] * b[2];
		o[2] = a[0] * b[1] - a[1] * b[0];
	endfunction

	// Round half away from zero after dropping the fraction, then clamp
	function automatic logic [31:0] round_clamp(input logic signed [63:0] v);
		logic [63:0] m;
		logic signed [63:0] r;
		m = (mag64(v) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
		r = v < 0 ? -$signed(m) : $signed(m);
		if (r > 64'sd2147483647) r = 64'sd2147483647;
		if (r < -64'sd2147483648) r = -64'sd2147483648;
		return r[31:0];
	endfunction

	function automatic logic [OUT_DW-1:0] build_view_matrix(input view_in_t vi);
		logic signed [63:0] from[3], diff[3], hint[3], fwd[3], raw[3], rgt[3], up[3];
		logic signed [63:0] s;
		logic [31:0] w[12];
		logic [OUT_DW-1:0] packed_out;
		from = '{vi.fx, vi.fy, vi.fz};
		diff = '{64'(vi.tx) - 64'(vi.fx), 64'(vi.ty) - 64'(vi.fy), 64'(vi.tz) - 64'(vi.fz)};
		hint = '{vi.hx, vi.hy, vi.hz};
		to_unit(diff, fwd);
		cross_vec(fwd, hint, raw);
		to_unit(raw, rgt);
		cross_vec(rgt, fwd, raw);
		for (int i = 0; i < 3; i++) begin
			up[i] = $signed(round_clamp(raw[i]));
			w[i] = rgt[i][31:0];
			w[3 + i] = fwd[i][31:0];
			w[6 + i] = up[i][31:0];
		end
		s = rgt[0] * from[0] + rgt[1] * from[1] + rgt[2] * from[2];
		w[9] = round_clamp(-s);
		s = fwd[0] * from[0] + fwd[1] * from[1] + fwd[2] * from[2];
		w[10] = round_clamp(-s);
		s = up[0] * from[0] + up[1] * from[1] + up[2] * from[2];
		w[11] = round_clamp(-s);
		for (int i = 0; i < 12; i++) packed_out[i*32 +: 32] = w[i];
		return packed_out;
	endfunction

	function automatic logic signed [31:0] rnd_word();
		case ($urandom_range(0, 7))
			0: return 32'sh7FFFFFFF;
			1: return 32'sh80000000;
			2: return 32'sd0;
			3, 4: return $signed(32'($urandom_range(0, 20 << 16))) - (10 << 16);
			default: return $signed($urandom);
		endcase
	endfunction

	function automatic view_in_t rnd_view();
		view_in_t v;
		v = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom};
		if ($urandom_range(0, 3) != 0) begin
			v.fx = rnd_word(); v.fy = rnd_word(); v.fz = rnd_word();
			v.tx = rnd_word(); v.ty = rnd_word(); v.tz = rnd_word();
			// mostly unit-ish hints along an axis
			v.hx = 0; v.hy = 0; v.hz = 0;
			case ($urandom_range(0, 3))
				0: v.hy = 32'sh10000;
				1: v.hz = -32'sh10000;
				2: begin v.hx = rnd_word(); v.hy = rnd_word(); v.hz = rnd_word(); end
				default: v.hx = 32'sh10000;
			endcase
			if ($urandom_range(0, 15) == 0) begin
				v.tx = v.fx; v.ty = v.fy; v.tz = v.fz;
			end
		end
		return v;
	endfunction

	function automatic view_in_t mk(input logic signed [31:0] fx, fy, fz, tx, ty, tz,
			hx, hy, hz);
		view_in_t v;
		v.fx = fx; v.fy = fy; v.fz = fz;
		v.tx = tx; v.ty = ty; v.tz = tz;
		v.hx = hx; v.hy = hy; v.hz = hz;
		return v;
	endfunction

	// Stimulus: directed views, then random ones
	initial begin
		localparam logic signed [31:0] ONE = 32'sh10000;
		localparam logic signed [31:0] MX  = 32'sh7FFFFFFF;
		localparam logic signed [31:0] MN  = 32'sh80000000;
		pending_views.push_back(mk(0, 0, 0, 0, 0, -ONE, 0, ONE, 0));
		pending_views.push_back(mk(ONE, 2*ONE, 3*ONE, 0, 0, 0, 0, ONE, 0));
		// target equal to position
		pending_views.push_back(mk(ONE, ONE, ONE, ONE, ONE, ONE, 0, ONE, 0));
		// view parallel to hint, and a zero hint
		pending_views.push_back(mk(0, 0, 0, 0, 5*ONE, 0, 0, ONE, 0));
		pending_views.push_back(mk(0, 0, 0, ONE, 0, 0, 0, 0, 0));
		// extremes: 33-bit difference, saturating shifts
		pending_views.push_back(mk(MN, MN, MN, MX, MX, MX, 0, ONE, 0));
		pending_views.push_back(mk(MX, MX, MX, MN, MN, MN, ONE, 0, 0));
		pending_views.push_back(mk(MX, MN, MX, 0, 0, 0, 0, 0, ONE));
		pending_views.push_back(mk(MN, MX, 0, MX, MN, -1, MX, MN, MX));
		// non-unit hints and tiny differences
		pending_views.push_back(mk(0, 0, 0, 1, 0, 0, 0, 7*ONE, 3));
		pending_views.push_back(mk(5, -3, 2, 6, -3, 1, MN, MN, MN));
		pending_views.push_back(mk(-1, -1, -1, 0, 0, 0, -1, -1, -1));
		pending_views.push_back(mk(MX, MX, MX, MX, MX, MX - 1, MX, MX, MX));
		pending_views.push_back('1);
		pending_views.push_back('0);
		for (int i = 0; i < N_RANDOM; i++) pending_views.push_back(rnd_view());
		all_queued = 1'b1;
	end

	// Whether the offered item was taken at the last rising edge
	always @(posedge clk) begin
		in_taken <= s_axis_tvalid && s_axis_tready;
	end

	// Driver: one item per handshake, gaps in bursts
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			src_gap       <= 0;
		end else if (s_axis_tvalid && !in_taken) begin
			// hold the offered item
		end else if (src_gap > 0) begin
			s_axis_tvalid <= 1'b0;
			src_gap       <= src_gap - 1;
		end else if (src_pause || pending_views.size() == 0) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			s_axis_tvalid <= 1'b1;
			s_axis_tdata  <= pending_views.pop_front();
			if (!quiet_phase && $urandom_range(0, 7) == 0)
				src_gap <= $urandom_range(1, 11);
		end
	end

	// Receiver ready: random bursts of stall plus one long hold-off
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			snk_gap       <= 0;
			hold_off      <= 0;
		end else if (hold_off > 0) begin
			m_axis_tready <= 1'b0;
			hold_off      <= hold_off - 1;
		end else if (snk_gap > 0) begin
			m_axis_tready <= 1'b0;
			snk_gap       <= snk_gap - 1;
		end else begin
			m_axis_tready <= 1'b1;
			if (!quiet_phase && !hold_done && pending_views.size() <= 1000 &&
					expected_mats.size() > 0) begin
				hold_off  <= 400;
				hold_done <= 1'b1;
			end else if (!quiet_phase && $urandom_range(0, 7) == 0)
				snk_gap <= $urandom_range(1, 11);
		end
	end

	// Input monitor: predict on every accepted item
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			expected_mats.push_back(build_view_matrix(view_in_t'(s_axis_tdata)));
	end

	// Output monitor: compare each word with the oldest prediction
	always @(posedge clk) begin
		logic [OUT_DW-1:0] exp_mat;
		int nbad;
		nbad = 0;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_mats.size() == 0) begin
				$display("%0t: unexpected item %h", $time, m_axis_tdata);
				nbad = 1;
			end else begin
				exp_mat = expected_mats.pop_front();
				for (int i = 0; i < 12; i++)
					if (exp_mat[i*32 +: 32] !== m_axis_tdata[i*32 +: 32]) begin
						$display("%0t: word %0d expected %h actual %h", $time, i,
							exp_mat[i*32 +: 32], m_axis_tdata[i*32 +: 32]);
						nbad = nbad + 1;
					end
			end
			if (nbad > 0)
				errors <= errors + nbad;
		end
	end

	// Watchdog: cycles with no handshake on either channel
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WD_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Sequencing: reset, a drain pause, a quiet tail, then the verdict
	initial begin
		quiet_phase = 1'b0;
		src_pause   = 1'b0;
		arst_n      = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		wait (all_queued && pending_views.size() <= 700);
		@(negedge clk) src_pause = 1'b1;
		wait (expected_mats.size() == 0);
		@(negedge clk) src_pause = 1'b0;
		wait (pending_views.size() <= 200);
		quiet_phase = 1'b1;
		wait (pending_views.size() == 0 && !s_axis_tvalid);
		@(posedge clk);
		wait (expected_mats.size() == 0);
		repeat (LATENCY + 20) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
